FILE: rtl/rsb_pkg.sv
// shared types and constants for the real split block to csr converter
// no dependencies
`timescale 1ns / 1ps

package rsb_pkg;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_DIM   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OMEGA = 8'd1;

   typedef enum logic [1:0] {
      KIND_ENTRY  = 2'd0,
      KIND_OFFSET = 2'd1,
      KIND_ERROR  = 2'd2
   } rsb_kind_type;

   typedef struct packed {
      rsb_kind_type kind;
      logic [4:0]   col_index;
      logic [63:0]  entry_bits;
      logic [10:0]  row_offset;
   } rsb_result_type;

   // request to the double multiplier
   typedef struct packed {
      logic        start;
      logic [63:0] op_a;
      logic [63:0] op_b;
   } rsb_mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } rsb_mul_rsp_type;

   // row store write and read controls, addresses travel beside them
   typedef struct packed {
      logic        wr_en;
      logic [63:0] stiff;
      logic [63:0] scaled_mass;
      logic        rd_en;
   } rsb_row_ctl_type;

endpackage

FILE: rtl/rsb_ifs.sv
// valid/ready channel interfaces: item input, result output, register writes
// depends on rsb_pkg
`timescale 1ns / 1ps

interface rsb_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] stiff_bits;
   logic [63:0] mass_bits;
   modport source (output valid, output stiff_bits, output mass_bits, input ready);
   modport sink   (input valid, input stiff_bits, input mass_bits, output ready);
endinterface

interface rsb_rsp_if;
   import rsb_pkg::*;
   logic         valid;
   logic         ready;
   rsb_kind_type kind;
   logic [4:0]   col_index;
   logic [63:0]  entry_bits;
   logic [10:0]  row_offset;
   logic         last;
   modport source (output valid, output kind, output col_index, output entry_bits,
                   output row_offset, output last, input ready);
   modport sink   (input valid, input kind, input col_index, input entry_bits,
                   input row_offset, input last, output ready);
endinterface

interface rsb_csr_if;
   import rsb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [63:0]          data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/rsb_fmul.sv
// multicycle ieee double multiplier, round to nearest even, finite operands
// four 27x27 partial products, bit-serial normalize, one denormal shift, round
// depends on rsb_pkg
`timescale 1ns / 1ps

module rsb_fmul
   import rsb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  rsb_mul_req_type req,
   output rsb_mul_rsp_type rsp
);

   typedef enum logic [4:0] {
      M_IDLE = 5'b00001,
      M_MUL  = 5'b00010,
      M_NORM = 5'b00100,
      M_SHR  = 5'b01000,
      M_RND  = 5'b10000
   } mstate_type;

   mstate_type         state_ff, state_in;
   logic               sign_ff, sign_in;
   logic [52:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic signed [12:0] exp_ff, exp_in;
   logic [105:0]       acc_ff, acc_in;
   logic               sticky_ff, sticky_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [53:0]        prod_ff, prod_in;
   logic [1:0]         pidx_ff, pidx_in;
   logic               done_ff, done_in;
   logic [63:0]        res_ff, res_in;

   logic [10:0]        ea, eb;
   logic               zero_op;
   logic [26:0]        opa, opb;
   logic [105:0]       pp_ext;
   logic signed [12:0] sh;
   logic [105:0]       sh_mask;
   logic [62:0]        rnd_sum;
   logic               rnd_inc;

   assign ea = (req.op_a[62:52] == 11'd0) ? 11'd1 : req.op_a[62:52];
   assign eb = (req.op_b[62:52] == 11'd0) ? 11'd1 : req.op_b[62:52];
   assign zero_op = (req.op_a[62:0] == 63'd0) || (req.op_b[62:0] == 63'd0);
   assign opa = cnt_ff[1] ? {1'b0, ma_ff[52:27]} : ma_ff[26:0];
   assign opb = cnt_ff[0] ? {1'b0, mb_ff[52:27]} : mb_ff[26:0];
   assign pp_ext = {52'd0, prod_ff} << (7'd27 * {5'd0, pidx_ff[1]} + 7'd27 * {5'd0, pidx_ff[0]});
   assign sh = 13'sd1 - exp_ff;
   assign sh_mask = (106'd1 << sh[6:0]) - 106'd1;
   assign rnd_inc = acc_ff[51] & ((|acc_ff[50:0]) | sticky_ff | acc_ff[52]);
   assign rnd_sum = {(acc_ff[104] ? exp_ff[10:0] : 11'd0), acc_ff[103:52]}
                    + {62'd0, rnd_inc};

   always_comb begin
      state_in  = state_ff;
      sign_in   = sign_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      exp_in    = exp_ff;
      acc_in    = acc_ff;
      sticky_in = sticky_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      pidx_in   = pidx_ff;
      done_in   = 1'b0;
      res_in    = res_ff;
      unique case (state_ff)
         M_IDLE: begin
            if (req.start) begin
               sign_in = req.op_a[63] ^ req.op_b[63];
               if (zero_op) begin
                  res_in  = {req.op_a[63] ^ req.op_b[63], 63'd0};
                  done_in = 1'b1;
               end else begin
                  ma_in     = {req.op_a[62:52] != 11'd0, req.op_a[51:0]};
                  mb_in     = {req.op_b[62:52] != 11'd0, req.op_b[51:0]};
                  exp_in    = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 13'sd1023;
                  acc_in    = '0;
                  sticky_in = 1'b0;
                  cnt_in    = 3'd0;
                  state_in  = M_MUL;
               end
            end
         end
         M_MUL: begin
            // product issued one cycle, summed the next
            if (cnt_ff != 3'd4) begin
               prod_in = opa * opb;
               pidx_in = cnt_ff[1:0];
            end
            if (cnt_ff != 3'd0) acc_in = acc_ff + pp_ext;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) state_in = M_NORM;
         end
         M_NORM: begin
            if (acc_ff[105]) begin
               acc_in    = acc_ff >> 1;
               sticky_in = sticky_ff | acc_ff[0];
               exp_in    = exp_ff + 13'sd1;
               state_in  = M_SHR;
            end else if (!acc_ff[104] && (exp_ff > 13'sd1)) begin
               acc_in = acc_ff << 1;
               exp_in = exp_ff - 13'sd1;
            end else begin
               state_in = M_SHR;
            end
         end
         M_SHR: begin
            // underflow: align to the denormal scale
            if (exp_ff < 13'sd1) begin
               if (sh >= 13'sd107) begin
                  acc_in    = '0;
                  sticky_in = sticky_ff | (|acc_ff);
               end else begin
                  acc_in    = acc_ff >> sh[6:0];
                  sticky_in = sticky_ff | (|(acc_ff & sh_mask));
               end
               exp_in = 13'sd1;
            end
            state_in = M_RND;
         end
         M_RND: begin
            if (exp_ff >= 13'sd2047) res_in = {sign_ff, 11'h7FF, 52'd0};
            else res_in = {sign_ff, rnd_sum};
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      sign_ff   <= sign_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      exp_ff    <= exp_in;
      acc_ff    <= acc_in;
      sticky_ff <= sticky_in;
      cnt_ff    <= cnt_in;
      prod_ff   <= prod_in;
      pidx_ff   <= pidx_in;
      res_ff    <= res_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = res_ff;

endmodule

FILE: rtl/rsb_row_mem.sv
// row store: stiffness and scaled mass of the current row, one entry per column
// synchronous write, registered read; depends on rsb_pkg
`timescale 1ns / 1ps

module rsb_row_mem
   import rsb_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic            clock,
   input  rsb_row_ctl_type ctl,
   input  logic [AW-1:0]   wr_addr,
   input  logic [AW-1:0]   rd_addr,
   output logic [63:0]     rd_stiff,
   output logic [63:0]     rd_scaled_mass
);

   logic [127:0] mem [DEPTH];
   logic [127:0] rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem[wr_addr] <= {ctl.stiff, ctl.scaled_mass};
      if (ctl.rd_en) rd_ff <= mem[rd_addr];
   end

   assign rd_stiff       = rd_ff[127:64];
   assign rd_scaled_mass = rd_ff[63:0];

endmodule

FILE: rtl/real_split_block_to_csr.sv
// channel   | dir | beat moves
// req_bus   | in  | one K and M element pair, row-major
// rsp_bus   | out | one csr entry, row offset or error, last on the item's final beat
// csr_bus   | in  | register write: 0 dim, 1 omega bits
// one item at a time, paced by the multicycle multiplier for w*M, which skips its steps
// for a zero operand; beats do not slow the sequencer unless the result port stalls.
// row end adds the offset beats and a replay of each column via the row store.
// subnormal operands add normalize steps. sync reset, no clearing pass.
// a stalled result port stalls the sequencer once the one-beat holding register is full.
// register writes wait for an idle, drained block and take priority over element beats.
// depends on rsb_pkg, rsb_ifs, rsb_fmul, rsb_row_mem
`timescale 1ns / 1ps

module real_split_block_to_csr
   import rsb_pkg::*;
#(
   parameter int MAX_DIM = 16
) (
   input  logic        clock,
   input  logic        reset,
   rsb_req_if.sink     req_bus,
   rsb_rsp_if.source   rsp_bus,
   rsb_csr_if.sink     csr_bus
);

   localparam int CW = $clog2(MAX_DIM + 1);
   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_MUL  = 10'b0000000010,
      S_PK   = 10'b0000000100,
      S_PW   = 10'b0000001000,
      S_OF1  = 10'b0000010000,
      S_RD   = 10'b0000100000,
      S_RN   = 10'b0001000000,
      S_RP   = 10'b0010000000,
      S_OF2  = 10'b0100000000,
      S_FIN  = 10'b1000000000
   } state_type;

   state_type      state_ff, state_in;
   logic [4:0]     dim_ff, dim_in;
   logic [63:0]    omega_ff, omega_in;
   logic [CW-1:0]  col_ff, col_in, row_ff, row_in;
   logic [10:0]    ecnt_ff, ecnt_in;
   logic           bad_ff, bad_in;
   logic [CW-1:0]  c_ff, c_in, n_ff, n_in, j_ff, j_in;
   logic           rowend_ff, rowend_in;
   logic [63:0]    k_ff, k_in, wm_ff, wm_in;
   logic           hold_v_ff, hold_v_in;
   rsb_result_type hold_ff, hold_in;
   logic           out_v_ff, out_v_in;
   rsb_result_type out_ff, out_in;
   logic           last_ff, last_in;

   rsb_mul_req_type mreq;
   rsb_mul_rsp_type mrsp;
   rsb_row_ctl_type rctl;
   logic [63:0]     rd_stiff, rd_wm;

   logic           in_acc, csr_acc, out_free, restart_now, bad_eff, nonfinite, step_ok;
   logic           cand_v;
   rsb_result_type cand;
   logic [CW-1:0]  n_eff, c_eff, r_eff, c_next;
   logic [AW-1:0]  j_addr;

   assign in_acc  = req_bus.valid && req_bus.ready;
   assign csr_acc = csr_bus.valid && csr_bus.ready;
   assign out_free = !out_v_ff || rsp_bus.ready;

   assign n_eff = (dim_ff == 5'd0) ? CW'(1) :
                  (dim_ff > 5'(MAX_DIM)) ? CW'(MAX_DIM) : dim_ff[CW-1:0];
   assign restart_now = (col_ff >= n_eff) || (row_ff >= n_eff);
   assign c_eff   = restart_now ? '0 : col_ff;
   assign r_eff   = restart_now ? '0 : row_ff;
   assign bad_eff = restart_now ? 1'b0 : bad_ff;
   assign c_next  = c_eff + CW'(1);
   assign nonfinite = (omega_ff[62:52] == 11'h7FF) || (req_bus.stiff_bits[62:52] == 11'h7FF)
                      || (req_bus.mass_bits[62:52] == 11'h7FF);
   assign j_addr = j_ff[AW-1:0];

   assign mreq.start = in_acc && !bad_eff && !nonfinite;
   assign mreq.op_a  = omega_ff;
   assign mreq.op_b  = req_bus.mass_bits;

   assign rctl.wr_en       = (state_ff == S_MUL) && mrsp.done;
   assign rctl.stiff       = k_ff;
   assign rctl.scaled_mass = mrsp.product;
   assign rctl.rd_en       = (state_ff == S_RD);

   rsb_fmul u_fmul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   rsb_row_mem #(.DEPTH(MAX_DIM), .AW(AW)) u_row_mem (
      .clock          (clock),
      .ctl            (rctl),
      .wr_addr        (c_ff[AW-1:0]),
      .rd_addr        (j_addr),
      .rd_stiff       (rd_stiff),
      .rd_scaled_mass (rd_wm)
   );

   // result candidate of the current sequencer step
   always_comb begin
      cand_v = 1'b0;
      cand   = '{kind: KIND_ENTRY, col_index: 5'd0, entry_bits: 64'd0, row_offset: 11'd0};
      unique case (state_ff)
         S_PK: begin
            cand_v = k_ff[62:0] != 63'd0;
            cand.col_index  = 5'(c_ff);
            cand.entry_bits = k_ff;
         end
         S_PW: begin
            cand_v = wm_ff[62:0] != 63'd0;
            cand.col_index  = 5'(c_ff) + 5'(n_ff);
            cand.entry_bits = wm_ff;
         end
         S_OF1, S_OF2: begin
            cand_v = 1'b1;
            cand.kind       = KIND_OFFSET;
            cand.row_offset = ecnt_ff;
         end
         S_RN: begin
            cand_v = rd_wm[62:0] != 63'd0;
            cand.col_index  = 5'(j_ff);
            cand.entry_bits = {~rd_wm[63], rd_wm[62:0]};
         end
         S_RP: begin
            cand_v = rd_stiff[62:0] != 63'd0;
            cand.col_index  = 5'(j_ff) + 5'(n_ff);
            cand.entry_bits = rd_stiff;
         end
         S_IDLE, S_MUL, S_RD, S_FIN: cand_v = 1'b0;
         default: cand_v = 1'b0;
      endcase
   end

   assign step_ok = !cand_v || !hold_v_ff || out_free;

   always_comb begin
      state_in  = state_ff;
      dim_in    = dim_ff;
      omega_in  = omega_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      ecnt_in   = ecnt_ff;
      bad_in    = bad_ff;
      c_in      = c_ff;
      n_in      = n_ff;
      j_in      = j_ff;
      rowend_in = rowend_ff;
      k_in      = k_ff;
      wm_in     = wm_ff;
      hold_v_in = hold_v_ff;
      hold_in   = hold_ff;
      out_v_in  = out_v_ff && !rsp_bus.ready;
      out_in    = out_ff;
      last_in   = last_ff;

      // a filled holding register moves on once the next beat is known
      if (cand_v && step_ok) begin
         if (hold_v_ff) begin
            out_v_in = 1'b1;
            out_in   = hold_ff;
            last_in  = 1'b0;
         end
         hold_v_in = 1'b1;
         hold_in   = cand;
         if (cand.kind == KIND_ENTRY) ecnt_in = ecnt_ff + 11'd1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (in_acc) begin
               // position advances whether or not the item yields anything
               col_in  = (c_next >= n_eff) ? '0 : c_next;
               row_in  = (c_next >= n_eff) ? r_eff + CW'(1) : r_eff;
               bad_in  = bad_eff;
               ecnt_in = restart_now ? 11'd0 : ecnt_ff;
               c_in    = c_eff;
               n_in    = n_eff;
               rowend_in = c_next == n_eff;
               k_in    = req_bus.stiff_bits;
               if (!bad_eff) begin
                  if (nonfinite) begin
                     bad_in    = 1'b1;
                     hold_v_in = 1'b1;
                     hold_in   = '{kind: KIND_ERROR, col_index: 5'd0, entry_bits: 64'd0,
                                   row_offset: 11'd0};
                     state_in  = S_FIN;
                  end else begin
                     state_in = S_MUL;
                  end
               end
            end
         end
         S_MUL: begin
            if (mrsp.done) begin
               wm_in    = mrsp.product;
               state_in = S_PK;
            end
         end
         S_PK:  if (step_ok) state_in = S_PW;
         S_PW:  if (step_ok) state_in = rowend_ff ? S_OF1 : S_FIN;
         S_OF1: begin
            if (step_ok) begin
               j_in     = '0;
               state_in = S_RD;
            end
         end
         S_RD:  state_in = S_RN;
         S_RN:  if (step_ok) state_in = S_RP;
         S_RP: begin
            if (step_ok) begin
               if (j_ff == n_ff - CW'(1)) begin
                  state_in = S_OF2;
               end else begin
                  j_in     = j_ff + CW'(1);
                  state_in = S_RD;
               end
            end
         end
         S_OF2: if (step_ok) state_in = S_FIN;
         S_FIN: begin
            if (!hold_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_v_in  = 1'b1;
               out_in    = hold_ff;
               last_in   = 1'b1;
               hold_v_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_acc && (csr_bus.index == REG_DIM || csr_bus.index == REG_OMEGA)) begin
         if (csr_bus.index == REG_DIM) dim_in = csr_bus.data[4:0];
         else omega_in = csr_bus.data;
         col_in  = '0;
         row_in  = '0;
         ecnt_in = 11'd0;
         bad_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         dim_ff    <= 5'd1;
         omega_ff  <= 64'd0;
         col_ff    <= '0;
         row_ff    <= '0;
         ecnt_ff   <= 11'd0;
         bad_ff    <= 1'b0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         dim_ff    <= dim_in;
         omega_ff  <= omega_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         ecnt_ff   <= ecnt_in;
         bad_ff    <= bad_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
      c_ff      <= c_in;
      n_ff      <= n_in;
      j_ff      <= j_in;
      rowend_ff <= rowend_in;
      k_ff      <= k_in;
      wm_ff     <= wm_in;
      hold_ff   <= hold_in;
      out_ff    <= out_in;
      last_ff   <= last_in;
   end

   // register writes only land with nothing in flight
   assign req_bus.ready      = (state_ff == S_IDLE) && !csr_bus.valid;
   assign csr_bus.ready      = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp_bus.valid      = out_v_ff;
   assign rsp_bus.kind       = out_ff.kind;
   assign rsp_bus.col_index  = out_ff.col_index;
   assign rsp_bus.entry_bits = out_ff.entry_bits;
   assign rsp_bus.row_offset = out_ff.row_offset;
   assign rsp_bus.last       = last_ff;

endmodule

FILE: rtl/rsb_checker.sv
// port-level checks on the result channel of real_split_block_to_csr
// depends on rsb_pkg; bound to the top level below
`timescale 1ns / 1ps

module rsb_checker
   import rsb_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsb_kind_type rsp_kind,
   input logic [4:0]   rsp_col_index,
   input logic [63:0]  rsp_entry_bits,
   input logic         rsp_last
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_bits) && $stable(rsp_kind))
      else $error("result beat changed under stall");

   // zeros of either sign are never emitted
   a_no_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ENTRY |-> rsp_entry_bits[62:0] != 63'd0)
      else $error("zero entry emitted");

   // an error beat carries last
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> rsp_last)
      else $error("error beat without last");

   a_meta_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ENTRY |-> rsp_col_index == 5'd0 && rsp_entry_bits == 64'd0)
      else $error("offset or error beat carries entry data");

endmodule

bind real_split_block_to_csr rsb_checker u_rsb_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_kind       (rsp_bus.kind),
   .rsp_col_index  (rsp_bus.col_index),
   .rsp_entry_bits (rsp_bus.entry_bits),
   .rsp_last       (rsp_bus.last)
);
